### sv/orlls_pkg.sv
package orlls_pkg;

    // Ring dimensions
    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int LEVEL_BITS   = 3;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = SLOT_W + 1;

    // Fixed request and result field widths
    localparam int FUNC_FW = 2;
    localparam int LVL_FW  = 3;
    localparam int PAY_FW  = 32;
    localparam int AGE_FW  = 6;
    localparam int CNT_FW  = 7;

    // Width at which stored and requested levels are compared
    localparam int LVL_CMP_W = 8;

    // Operation codes
    localparam logic [FUNC_FW-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_FW-1:0] FUNC_GET   = 2'd1;
    localparam logic [FUNC_FW-1:0] FUNC_FIND  = 2'd2;
    localparam logic [FUNC_FW-1:0] FUNC_CLEAR = 2'd3;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_AGE  = 1'b1;

    typedef struct packed {
        logic [FUNC_FW-1:0] func;
        logic [LVL_FW-1:0]  entry_level;
        logic [PAY_FW-1:0]  entry_payload;
        logic [AGE_FW-1:0]  age;
        logic [LVL_FW-1:0]  floor_level;
        logic [CNT_FW-1:0]  max_matches;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [LVL_FW-1:0]  read_level;
        logic [PAY_FW-1:0]  read_payload;
        logic               match_valid;
        logic [AGE_FW-1:0]  match_age;
        logic [CNT_FW-1:0]  entry_count;
        logic               ring_empty;
        logic               last;
    } t_res;

    // One stored log entry
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [LEVEL_BITS-1:0]   level;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer to ring datapath
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic [SLOT_W-1:0] rd_age;
        t_entry            wdata;
    } t_ring_cmd;

    // Ring datapath to sequencer
    typedef struct packed {
        logic [CNT_W-1:0] count;
        t_entry           rdata;
    } t_ring_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DONE,
        S_GETW,
        S_SCAN,
        S_FLUSH
    } t_state;

endpackage

### sv/orlls_ram.sv
module orlls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/orlls_ctrl.sv
module orlls_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  orlls_pkg::t_req     i_req,
    output logic                busy,
    output logic                o_strobe,
    output orlls_pkg::t_res     o_res,
    output orlls_pkg::t_ring_cmd o_cmd,
    input  orlls_pkg::t_ring_sts i_sts
);

    import orlls_pkg::*;

    t_state            r_state,    n_state;
    t_req              r_req,      n_req;
    logic [CNT_W-1:0]  r_age,      n_age;
    logic [CNT_FW-1:0] r_found,    n_found;
    logic              r_pend,     n_pend;
    logic [AGE_FW-1:0] r_pend_age, n_pend_age;
    t_res              r_res,      n_res;
    logic              r_strobe,   n_strobe;

    t_res              res_base;
    logic              hit;
    logic [CNT_W-1:0]  age_inc;
    logic [CNT_FW-1:0] found_inc;
    logic              scan_end;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
        end
    end

    // Request, scan position and result holding
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_age      <= n_age;
        r_found    <= n_found;
        r_pend_age <= n_pend_age;
        r_res      <= n_res;
    end

    // Scan helpers
    always_comb begin
        hit       = LVL_CMP_W'(i_sts.rdata.level) >= LVL_CMP_W'(r_req.floor_level);
        age_inc   = r_age + CNT_W'(1);
        found_inc = r_found + CNT_FW'(1);
        scan_end  = (age_inc == i_sts.count) || (hit && (found_inc >= r_req.max_matches));
    end

    // Common result fields: ring occupancy after the operation
    always_comb begin
        res_base             = '0;
        res_base.entry_count = CNT_FW'(i_sts.count);
        res_base.ring_empty  = (i_sts.count == '0);
        res_base.last        = 1'b1;
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_age      = r_age;
        n_found    = r_found;
        n_pend     = r_pend;
        n_pend_age = r_pend_age;
        n_res      = r_res;
        n_strobe   = 1'b0;

        o_cmd               = '0;
        o_cmd.wdata.level   = LEVEL_BITS'(r_req.entry_level);
        o_cmd.wdata.payload = PAYLOAD_BITS'(r_req.entry_payload);
        o_cmd.rd_age        = SLOT_W'(r_age);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_req.func)
                    FUNC_PUSH: begin
                        o_cmd.wr = 1'b1;
                        n_state  = S_DONE;
                    end
                    FUNC_CLEAR: begin
                        o_cmd.clr = 1'b1;
                        n_state   = S_DONE;
                    end
                    FUNC_GET: begin
                        if (CNT_FW'(r_req.age) >= CNT_FW'(i_sts.count)) begin
                            n_res        = res_base;
                            n_res.status = STATUS_BAD_AGE;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.rd_age = SLOT_W'(r_req.age);
                            n_state      = S_GETW;
                        end
                    end
                    FUNC_FIND: begin
                        if (i_sts.count == '0 || r_req.max_matches == '0) begin
                            n_res    = res_base;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            o_cmd.rd_age = '0;
                            n_age        = '0;
                            n_found      = '0;
                            n_pend       = 1'b0;
                            n_state      = S_SCAN;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DONE: begin
                // ring pointers already updated here
                n_res    = res_base;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_GETW: begin
                n_res              = res_base;
                n_res.read_level   = LVL_FW'(i_sts.rdata.level);
                n_res.read_payload = PAY_FW'(i_sts.rdata.payload);
                n_strobe           = 1'b1;
                n_state            = S_IDLE;
            end
            S_SCAN: begin
                // read data belongs to r_age; fetch the next age meanwhile
                o_cmd.rd_age = scan_end ? SLOT_W'(r_age) : SLOT_W'(age_inc);
                if (hit) begin
                    // a held match is known not to be last once another turns up
                    if (r_pend) begin
                        n_res             = res_base;
                        n_res.match_valid = 1'b1;
                        n_res.match_age   = r_pend_age;
                        n_res.last        = 1'b0;
                        n_strobe          = 1'b1;
                    end
                    n_pend     = 1'b1;
                    n_pend_age = AGE_FW'(r_age);
                    n_found    = found_inc;
                end
                if (scan_end) begin
                    if (hit || r_pend) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_res    = res_base;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_age = age_inc;
                end
            end
            S_FLUSH: begin
                n_res             = res_base;
                n_res.match_valid = 1'b1;
                n_res.match_age   = r_pend_age;
                n_strobe          = 1'b1;
                n_pend            = 1'b0;
                n_state           = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted request");

    a_push_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.func == FUNC_PUSH |-> ##3 o_strobe)
        else $error("push result not delivered on time");

    a_match_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.match_valid |-> CNT_FW'(o_res.match_age) < o_res.entry_count)
        else $error("match age outside the valid entries");

    a_bad_age_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.status |-> o_res.last && !o_res.match_valid)
        else $error("out of range get not a single final result");

endmodule

### sv/overwrite_ring_log_with_level_scan_core.sv
// Push and clear: executed in S_EXEC, then the result is strobed from S_DONE; busy through both.
// Get: strobed from S_GETW, or from S_EXEC when the age lies outside the valid entries.
// Find: newest first, one entry a cycle through the single read port of the entry RAM;
// the held last match is strobed from S_FLUSH, an empty ring or a zero limit from S_EXEC;
// matches are strobed at most one per cycle, the last marked.
// Results cannot be held off. Synchronous active-low reset empties the ring at once;
// entry RAM contents are not cleared and are only read inside the valid window.
module overwrite_ring_log_with_level_scan_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  orlls_pkg::t_req i_req,
    output logic            busy,
    output logic            o_strobe,
    output orlls_pkg::t_res o_res
);

    import orlls_pkg::*;

    t_ring_cmd         cmd;
    t_ring_sts         sts;
    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] rd_slot;
    logic [ENTRY_W-1:0] rdata;

    // Ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_count <= '0;
        end else begin
            r_wslot <= n_wslot;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_wslot = r_wslot;
        n_count = r_count;
        if (cmd.clr) begin
            n_wslot = '0;
            n_count = '0;
        end else if (cmd.wr) begin
            n_wslot = (r_wslot == SLOT_W'(CAPACITY - 1)) ? '0 : r_wslot + SLOT_W'(1);
            if (r_count < CNT_W'(CAPACITY)) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Age to slot: newest sits just behind the write slot
    always_comb begin
        slot_sum = SUM_W'(r_wslot) + SUM_W'(CAPACITY - 1) - SUM_W'(cmd.rd_age);
        rd_slot  = (slot_sum >= SUM_W'(CAPACITY)) ? SLOT_W'(slot_sum - SUM_W'(CAPACITY))
                                                  : SLOT_W'(slot_sum);
    end

    orlls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (cmd.wr),
        .i_waddr (r_wslot),
        .i_wdata (cmd.wdata),
        .i_raddr (rd_slot),
        .o_rdata (rdata)
    );

    assign sts = {r_count, rdata};

    orlls_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

endmodule
